// ----- sv/mbe_pkg.sv -----
package mbe_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int ITER_BITS  = 16;
  localparam int COORD_BITS = 12;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int VAL_W      = 32;
  localparam int STEP_W     = 31;
  localparam int MAG_W      = 38;
  localparam int WIDE_W     = 64;
  localparam int DIFF_W     = COORD_BITS + 2;
  localparam int MAP_W      = DIFF_W + STEP_W + 1;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT  = 3'd5;

  localparam logic [VAL_W-1:0]     RST_CENTER  = '0;
  localparam logic [STEP_W-1:0]    RST_STEP    = 31'd1677722;
  localparam logic [ITER_BITS-1:0] RST_MAX_ITER = 16'd256;
  localparam logic [SIZE_BITS-1:0] RST_WIDTH   = 13'd640;
  localparam logic [SIZE_BITS-1:0] RST_HEIGHT  = 13'd480;

  localparam logic [WIDE_W-1:0] FOUR    = 64'd4 << (2 * FRAC_BITS);
  localparam logic [WIDE_W-1:0] MAG_MAX = (64'd1 << MAG_W) - 64'd1;

  localparam logic signed [WIDE_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [VAL_W-1:0]     center_real;
    logic [VAL_W-1:0]     center_imag;
    logic [STEP_W-1:0]    pixel_step;
    logic [ITER_BITS-1:0] max_iterations;
    logic [SIZE_BITS-1:0] image_width;
    logic [SIZE_BITS-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] re;
    logic [VAL_W-1:0] im;
  } coord_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } st_t;

  function automatic logic [VAL_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[VAL_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/mbe_front.sv -----
module mbe_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mbe_pkg::cfg_t                        cfg,
  input  logic                                 pix_valid,
  output logic                                 pix_ready,
  input  logic [mbe_pkg::COORD_BITS-1:0]       pix_x,
  input  logic [mbe_pkg::COORD_BITS-1:0]       pix_y,
  output logic                                 push,
  input  logic                                 q_full,
  output mbe_pkg::coord_t                      push_data
);

  logic                                  p1_valid_r;
  logic                                  p1_valid_nxt;
  logic signed [mbe_pkg::MAP_W-1:0]      prod_re_r;
  logic signed [mbe_pkg::MAP_W-1:0]      prod_im_r;
  logic signed [mbe_pkg::DIFF_W-1:0]     d_re;
  logic signed [mbe_pkg::DIFF_W-1:0]     d_im;
  logic signed [mbe_pkg::STEP_W:0]       step_s;
  logic signed [mbe_pkg::MAP_W-1:0]      off_re;
  logic signed [mbe_pkg::MAP_W-1:0]      off_im;
  logic signed [mbe_pkg::WIDE_W-1:0]     sum_re;
  logic signed [mbe_pkg::WIDE_W-1:0]     sum_im;
  logic                                  take;

  // offset from centre in half steps: 2*pos + 1 - size
  assign d_re   = $signed({1'b0, pix_x, 1'b1}) - $signed({1'b0, cfg.image_width});
  assign d_im   = $signed({1'b0, pix_y, 1'b1}) - $signed({1'b0, cfg.image_height});
  assign step_s = $signed({1'b0, cfg.pixel_step});

  assign push      = p1_valid_r && !q_full;
  assign pix_ready = !p1_valid_r || push;
  assign take      = pix_valid && pix_ready;

  assign off_re = prod_re_r >>> 1;
  assign off_im = prod_im_r >>> 1;
  assign sum_re = mbe_pkg::WIDE_W'(off_re) + mbe_pkg::WIDE_W'($signed(cfg.center_real));
  assign sum_im = mbe_pkg::WIDE_W'(off_im) + mbe_pkg::WIDE_W'($signed(cfg.center_imag));

  assign push_data.re = mbe_pkg::sat_coord(sum_re);
  assign push_data.im = mbe_pkg::sat_coord(sum_im);

  always_comb begin
    p1_valid_nxt = p1_valid_r;
    if (take) begin
      p1_valid_nxt = 1'b1;
    end else if (push) begin
      p1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod_re_r <= d_re * step_s;
      prod_im_r <= d_im * step_s;
    end
  end

endmodule

// ----- sv/mbe_queue.sv -----
module mbe_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbe_pkg::coord_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output mbe_pkg::coord_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mbe_pkg::coord_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/mbe_back.sv -----
module mbe_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mbe_pkg::ITER_BITS-1:0]     max_iterations,
  input  logic                              q_not_empty,
  output logic                              pop,
  input  mbe_pkg::coord_t                   pop_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic                              res_escaped,
  output logic [mbe_pkg::ITER_BITS-1:0]     res_count,
  output logic [mbe_pkg::MAG_W-1:0]         res_mag
);

  mbe_pkg::st_t state_r;
  mbe_pkg::st_t state_nxt;

  logic [mbe_pkg::VAL_W-1:0]          cr_r;
  logic [mbe_pkg::VAL_W-1:0]          ci_r;
  logic signed [mbe_pkg::VAL_W-1:0]   re_r;
  logic signed [mbe_pkg::VAL_W-1:0]   im_r;
  logic signed [mbe_pkg::WIDE_W-1:0]  rr_r;
  logic signed [mbe_pkg::WIDE_W-1:0]  ii_r;
  logic signed [mbe_pkg::WIDE_W-1:0]  ri_r;
  logic [mbe_pkg::ITER_BITS-1:0]      count_r;

  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic                               out_escaped_r;
  logic [mbe_pkg::ITER_BITS-1:0]      out_count_r;
  logic [mbe_pkg::MAG_W-1:0]          out_mag_r;

  logic [mbe_pkg::WIDE_W-1:0]         mag;
  logic [mbe_pkg::WIDE_W-1:0]         mag_sh;
  logic [mbe_pkg::MAG_W-1:0]          mag_sat;
  logic signed [mbe_pkg::WIDE_W-1:0]  nre_sum;
  logic signed [mbe_pkg::WIDE_W-1:0]  nim_sum;
  logic                               go_on;
  logic                               slot_free;
  logic                               mul_en;
  logic                               upd_en;
  logic                               load_out;

  assign mag     = $unsigned(rr_r) + $unsigned(ii_r);
  assign mag_sh  = mag >> mbe_pkg::FRAC_BITS;
  assign mag_sat = (mag_sh > mbe_pkg::MAG_MAX) ? mbe_pkg::MAG_MAX[mbe_pkg::MAG_W-1:0]
                                               : mag_sh[mbe_pkg::MAG_W-1:0];
  assign go_on   = (mag <= mbe_pkg::FOUR) && (count_r < max_iterations);

  assign nre_sum = ((rr_r - ii_r) >>> mbe_pkg::FRAC_BITS)
                 + mbe_pkg::WIDE_W'($signed(cr_r));
  assign nim_sum = (ri_r >>> (mbe_pkg::FRAC_BITS - 1))
                 + mbe_pkg::WIDE_W'($signed(ci_r));

  assign slot_free = !out_valid_r || res_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbe_pkg::ST_IDLE: begin
        if (q_not_empty) begin
          state_nxt = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_MUL: begin
        state_nxt = mbe_pkg::ST_ADD;
      end
      mbe_pkg::ST_ADD: begin
        state_nxt = go_on ? mbe_pkg::ST_MUL : mbe_pkg::ST_OUT;
      end
      mbe_pkg::ST_OUT: begin
        if (slot_free) begin
          state_nxt = mbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mul_en   = 1'b0;
    upd_en   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      mbe_pkg::ST_IDLE: begin
        pop = q_not_empty;
      end
      mbe_pkg::ST_MUL: begin
        mul_en = 1'b1;
      end
      mbe_pkg::ST_ADD: begin
        upd_en = go_on;
      end
      mbe_pkg::ST_OUT: begin
        load_out = slot_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbe_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cr_r    <= pop_data.re;
      ci_r    <= pop_data.im;
      re_r    <= '0;
      im_r    <= '0;
      count_r <= '0;
    end else if (upd_en) begin
      re_r    <= mbe_pkg::sat_coord(nre_sum);
      im_r    <= mbe_pkg::sat_coord(nim_sum);
      count_r <= count_r + mbe_pkg::ITER_BITS'(1);
    end
    if (mul_en) begin
      rr_r <= re_r * re_r;
      ii_r <= im_r * im_r;
      ri_r <= re_r * im_r;
    end
    if (load_out) begin
      out_escaped_r <= (mag > mbe_pkg::FOUR);
      out_count_r   <= count_r;
      out_mag_r     <= mag_sat;
    end
  end

  assign res_valid   = out_valid_r;
  assign res_escaped = out_escaped_r;
  assign res_count   = out_count_r;
  assign res_mag     = out_mag_r;

endmodule

// ----- sv/mandelbrot_escape_time_core.sv -----
// the iteration engine works on one pixel at a time, alternating a multiply state
// and an update state for each iteration; the front end and queue keep accepting
// new pixels while it iterates, until the queue is full
// reset: synchronous active-low rst_n empties the queue and pipeline and
// loads the configuration registers with their default values
module mandelbrot_escape_time_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_x[11:0], pixel_y[23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // iteration_count[15:0], magnitude_sq[53:16], zero pad
  output logic        out_tuser   // escaped
);

  mbe_pkg::cfg_t   cfg_r;
  mbe_pkg::coord_t push_data;
  mbe_pkg::coord_t pop_data;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_not_empty;
  logic [mbe_pkg::ITER_BITS-1:0] res_count;
  logic [mbe_pkg::MAG_W-1:0]     res_mag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_real    <= mbe_pkg::RST_CENTER;
      cfg_r.center_imag    <= mbe_pkg::RST_CENTER;
      cfg_r.pixel_step     <= mbe_pkg::RST_STEP;
      cfg_r.max_iterations <= mbe_pkg::RST_MAX_ITER;
      cfg_r.image_width    <= mbe_pkg::RST_WIDTH;
      cfg_r.image_height   <= mbe_pkg::RST_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        mbe_pkg::REG_CENTER_REAL: cfg_r.center_real    <= cfg_data;
        mbe_pkg::REG_CENTER_IMAG: cfg_r.center_imag    <= cfg_data;
        mbe_pkg::REG_PIXEL_STEP:  cfg_r.pixel_step     <= cfg_data[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_MAX_ITER:    cfg_r.max_iterations <= cfg_data[mbe_pkg::ITER_BITS-1:0];
        mbe_pkg::REG_IMG_WIDTH:   cfg_r.image_width    <= cfg_data[mbe_pkg::SIZE_BITS-1:0];
        mbe_pkg::REG_IMG_HEIGHT:  cfg_r.image_height   <= cfg_data[mbe_pkg::SIZE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pix_valid (in_tvalid),
    .pix_ready (in_tready),
    .pix_x     (in_tdata[11:0]),
    .pix_y     (in_tdata[23:12]),
    .push      (push),
    .q_full    (q_full),
    .push_data (push_data)
  );

  mbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  mbe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .max_iterations (cfg_r.max_iterations),
    .q_not_empty    (q_not_empty),
    .pop            (pop),
    .pop_data       (pop_data),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .res_escaped    (out_tuser),
    .res_count      (res_count),
    .res_mag        (res_mag)
  );

  assign out_tdata = {2'b00, res_mag, res_count};

endmodule

// ----- dv/mandelbrot_escape_time_core_tb.sv -----
`timescale 1ns / 1ps

module mandelbrot_escape_time_core_tb;

  localparam int unsigned CYCLE_LIMIT      = 4_000_000;
  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam int          RANDOM_PHASES    = 15;
  localparam int          PIXELS_PER_PHASE = 30;

  // indexes past the register file, writes there must be dropped
  localparam logic [mbe_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [mbe_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [11:0]                   px;
    logic [11:0]                   py;
    logic                          escaped;
    logic [mbe_pkg::ITER_BITS-1:0] iters;
    logic [mbe_pkg::MAG_W-1:0]     mag_sq;
  } escape_result_t;

  typedef struct {
    bit                            is_write;
    logic [mbe_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [31:0]                   reg_data;
    logic [11:0]                   px;
    logic [11:0]                   py;
    bit                            typed;
    escape_result_t                want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // pixel_x[11:0], pixel_y[23:12]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // iteration_count[15:0], magnitude_sq[53:16], zero pad
  logic        out_tuser;  // escaped

  mbe_pkg::cfg_t  plane;
  escape_result_t expected_escapes[$];
  stim_row_t      directed_rows[$];
  escape_result_t seen_want;

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned results_checked;
  int unsigned escaped_seen;
  int unsigned writes_done;
  bit          steady_source;
  bit          steady_sink;
  bit          hold_sink_request;

  mandelbrot_escape_time_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_escapes.size());
      $display("mandelbrot_escape_time_core_tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [63:0] clamp_s32(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX;
    end else if (v < S32_MIN) begin
      r = S32_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] pixel_to_plane(
      input logic [11:0] pos,
      input logic [mbe_pkg::SIZE_BITS-1:0] size,
      input logic [mbe_pkg::VAL_W-1:0] centre);
    logic signed [63:0] d;
    logic signed [63:0] off;
    logic signed [63:0] base;
    d    = 2 * $signed({52'd0, pos}) + 64'sd1 - $signed({51'd0, size});
    off  = (d * $signed({33'd0, plane.pixel_step})) >>> 1;
    base = $signed(centre);
    return clamp_s32(base + off);
  endfunction

  function automatic escape_result_t escape_time_of(input logic [11:0] px,
                                                    input logic [11:0] py);
    logic signed [63:0] c_re, c_im, re, im, rr, ii, nre;
    logic [63:0]        mag;
    logic [63:0]        mag_out;
    int unsigned        steps;
    escape_result_t     r;
    c_re  = pixel_to_plane(px, plane.image_width, plane.center_real);
    c_im  = pixel_to_plane(py, plane.image_height, plane.center_imag);
    re    = '0;
    im    = '0;
    rr    = '0;
    ii    = '0;
    mag   = '0;
    steps = 0;
    while (mag <= mbe_pkg::FOUR && steps < plane.max_iterations) begin
      nre   = clamp_s32(((rr - ii) >>> mbe_pkg::FRAC_BITS) + c_re);
      im    = clamp_s32(((re * im) >>> (mbe_pkg::FRAC_BITS - 1)) + c_im);
      re    = nre;
      rr    = re * re;
      ii    = im * im;
      mag   = rr + ii;
      steps++;
    end
    mag_out = mag >> mbe_pkg::FRAC_BITS;
    if (mag_out > mbe_pkg::MAG_MAX) mag_out = mbe_pkg::MAG_MAX;
    r.px      = px;
    r.py      = py;
    r.escaped = (mag > mbe_pkg::FOUR);
    r.iters   = steps[mbe_pkg::ITER_BITS-1:0];
    r.mag_sq  = mag_out[mbe_pkg::MAG_W-1:0];
    return r;
  endfunction

  function automatic void latch_register(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [31:0] data);
    case (idx)
      mbe_pkg::REG_CENTER_REAL: plane.center_real    = data;
      mbe_pkg::REG_CENTER_IMAG: plane.center_imag    = data;
      mbe_pkg::REG_PIXEL_STEP:  plane.pixel_step     = data[mbe_pkg::STEP_W-1:0];
      mbe_pkg::REG_MAX_ITER:    plane.max_iterations = data[mbe_pkg::ITER_BITS-1:0];
      mbe_pkg::REG_IMG_WIDTH:   plane.image_width    = data[mbe_pkg::SIZE_BITS-1:0];
      mbe_pkg::REG_IMG_HEIGHT:  plane.image_height   = data[mbe_pkg::SIZE_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic void add_write(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] data);
    stim_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_pixel(input logic [11:0] px, input logic [11:0] py);
    stim_row_t row;
    row    = '{default: '0};
    row.px = px;
    row.py = py;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic [11:0] px, input logic [11:0] py,
                                    input logic esc,
                                    input logic [mbe_pkg::ITER_BITS-1:0] iters,
                                    input logic [mbe_pkg::MAG_W-1:0] mag_sq);
    stim_row_t row;
    row              = '{default: '0};
    row.px           = px;
    row.py           = py;
    row.typed        = 1'b1;
    row.want.px      = px;
    row.want.py      = py;
    row.want.escaped = esc;
    row.want.iters   = iters;
    row.want.mag_sq  = mag_sq;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [11:0] pick_coord(input logic [mbe_pkg::SIZE_BITS-1:0] size);
    logic [11:0] c;
    if (size == 0 || $urandom_range(0, 7) == 0) begin
      c = 12'($urandom);
    end else begin
      c = 12'($urandom_range(0, ((size > 4096) ? 4096 : size) - 1));
    end
    return c;
  endfunction

  task automatic write_reg(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    latch_register(idx, data);
    writes_done++;
  endtask

  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                            input bit typed, input escape_result_t typed_want);
    int unsigned gap;
    cfg_valid <= 1'b0;
    if (!steady_source && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {py, px};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_escapes.push_back(typed ? typed_want : escape_time_of(px, py));
    pixels_sent++;
  endtask

  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    while (expected_escapes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_escapes.size() == 0) begin
        $error("result word with no pixel pending");
        mismatches++;
      end else begin
        seen_want = expected_escapes.pop_front();
        if (out_tuser !== seen_want.escaped) begin
          $error("pixel (%0d,%0d) escaped: expected %0d, got %0d",
                 seen_want.px, seen_want.py, seen_want.escaped, out_tuser);
          mismatches++;
        end
        if (out_tdata[15:0] !== seen_want.iters) begin
          $error("pixel (%0d,%0d) iteration_count: expected %0d, got %0d",
                 seen_want.px, seen_want.py, seen_want.iters, out_tdata[15:0]);
          mismatches++;
        end
        if (out_tdata[53:16] !== seen_want.mag_sq) begin
          $error("pixel (%0d,%0d) magnitude_sq: expected %0d, got %0d",
                 seen_want.px, seen_want.py, seen_want.mag_sq, out_tdata[53:16]);
          mismatches++;
        end
        results_checked++;
        if (seen_want.escaped) escaped_seen++;
      end
    end
  end

  // result sink
  initial begin : sink_side
    int unsigned gap;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_sink_request) begin
        hold_sink_request = 1'b0;
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end else if (steady_sink || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : source_side
    escape_result_t no_want;
    bit             last_was_write;
    int unsigned    wd, ht, span, mi, pick;
    logic [31:0]    cre, cim, stp;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    no_want   = '0;
    plane.center_real    = mbe_pkg::RST_CENTER;
    plane.center_imag    = mbe_pkg::RST_CENTER;
    plane.pixel_step     = mbe_pkg::RST_STEP;
    plane.max_iterations = mbe_pkg::RST_MAX_ITER;
    plane.image_width    = mbe_pkg::RST_WIDTH;
    plane.image_height   = mbe_pkg::RST_HEIGHT;

    // after reset, default view
    add_pixel(0, 0);
    add_pixel(639, 479);
    add_pixel(320, 240);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    // zero iteration limit
    add_write(mbe_pkg::REG_MAX_ITER, 32'd0);
    add_typed(0, 0, 1'b0, 16'd0, 38'd0);
    add_typed(4095, 4095, 1'b0, 16'd0, 38'd0);
    // zero step, origin stays at z = 0
    add_write(mbe_pkg::REG_MAX_ITER, 32'd5);
    add_write(mbe_pkg::REG_PIXEL_STEP, 32'd0);
    add_typed(0, 0, 1'b0, 16'd5, 38'd0);
    add_typed(4095, 2048, 1'b0, 16'd5, 38'd0);
    // most negative corner, escapes on the first step
    add_write(mbe_pkg::REG_CENTER_REAL, 32'h8000_0000);
    add_write(mbe_pkg::REG_CENTER_IMAG, 32'h8000_0000);
    add_typed(7, 9, 1'b1, 16'd1, 38'h8_0000_0000);
    add_write(mbe_pkg::REG_CENTER_REAL, 32'h7FFF_FFFF);
    add_write(mbe_pkg::REG_CENTER_IMAG, 32'h7FFF_FFFF);
    add_pixel(1, 1);
    // huge step saturates the mapping
    add_write(mbe_pkg::REG_PIXEL_STEP, 32'hFFFF_FFFF);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    // zero image size
    add_write(mbe_pkg::REG_IMG_WIDTH, 32'd0);
    add_write(mbe_pkg::REG_IMG_HEIGHT, 32'd0);
    add_write(mbe_pkg::REG_CENTER_REAL, 32'd0);
    add_write(mbe_pkg::REG_CENTER_IMAG, 32'd0);
    add_write(mbe_pkg::REG_PIXEL_STEP, 32'd1 << 20);
    add_pixel(0, 0);
    add_pixel(3, 4095);
    // unmapped indexes
    add_write(REG_SPARE_6, 32'hFFFF_FFFF);
    add_write(REG_SPARE_7, 32'h1234_5678);
    add_pixel(2, 2);
    add_write(mbe_pkg::REG_IMG_WIDTH, 32'h0000_1FFF);
    add_write(mbe_pkg::REG_IMG_HEIGHT, 32'hFFFF_FFFF);
    add_write(mbe_pkg::REG_PIXEL_STEP, 32'd1);
    add_pixel(4095, 4095);
    add_pixel(0, 0);
    // default view at the full iteration limit, centre pixel stays inside
    add_write(mbe_pkg::REG_IMG_WIDTH, 32'd640);
    add_write(mbe_pkg::REG_IMG_HEIGHT, 32'd480);
    add_write(mbe_pkg::REG_PIXEL_STEP, 32'd1677722);
    add_write(mbe_pkg::REG_MAX_ITER, 32'hFFFF_FFFF);
    add_pixel(320, 240);
    add_pixel(0, 0);

    do @(posedge clk); while (!rst_n);

    last_was_write = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        if (!last_was_write) drain_pixels();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_pixel(directed_rows[i].px, directed_rows[i].py, directed_rows[i].typed,
                   directed_rows[i].want);
      end
      last_was_write = directed_rows[i].is_write;
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_pixels();
      steady_source = 1'b0;
      steady_sink   = 1'b0;
      if (phase == 0) begin
        // lowest corner, smallest step and image, full limit
        cre = 32'h8000_0000;
        cim = 32'h8000_0000;
        stp = 32'd1;
        mi  = 65535;
        wd  = 1;
        ht  = 1;
      end else if (phase == 1) begin
        cre = 32'h7FFF_FFFF;
        cim = 32'h7FFF_FFFF;
        stp = 32'h7FFF_FFFF;
        mi  = 3;
        wd  = 8191;
        ht  = 8191;
      end else begin
        pick = $urandom_range(0, 5);
        wd   = (pick == 0) ? $urandom : $urandom_range(1, 64);
        ht   = (pick == 0) ? $urandom : $urandom_range(1, 64);
        span = ((wd % 8192) > (ht % 8192)) ? (wd % 8192) : (ht % 8192);
        if ($urandom_range(0, 7) == 0) begin
          cre = $urandom;
          cim = $urandom;
          stp = $urandom;
        end else begin
          cre = 32'(-671088640 + int'($urandom_range(0, 939524096)));
          cim = 32'(-335544320 + int'($urandom_range(0, 671088640)));
          stp = 32'((longint'(805306368) / (span + 1)) * $urandom_range(50, 150) / 100);
        end
        pick = $urandom_range(0, 19);
        if (phase == 2 || phase == 3) mi = $urandom_range(1, 8);
        else if (pick == 0) mi = 0;
        else if (pick < 4) mi = 256;
        else mi = $urandom_range(1, 40);
      end
      write_reg(mbe_pkg::REG_CENTER_REAL, cre);
      write_reg(mbe_pkg::REG_CENTER_IMAG, cim);
      write_reg(mbe_pkg::REG_PIXEL_STEP, stp);
      write_reg(mbe_pkg::REG_MAX_ITER, mi);
      write_reg(mbe_pkg::REG_IMG_WIDTH, wd);
      write_reg(mbe_pkg::REG_IMG_HEIGHT, ht);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_6, $urandom);
      if (phase == 2) begin
        // back up the whole pipe behind a stalled sink
        steady_source     = 1'b1;
        hold_sink_request = 1'b1;
      end else if (phase == 3) begin
        steady_source = 1'b1;
        steady_sink   = 1'b1;
      end
      repeat (PIXELS_PER_PHASE) send_pixel(pick_coord(plane.image_width),
                                           pick_coord(plane.image_height), 1'b0, no_want);
    end

    drain_pixels();
    repeat (50) @(posedge clk);

    $display("%0d pixels sent, %0d results checked (%0d escaped, %0d inside)",
             pixels_sent, results_checked, escaped_seen, results_checked - escaped_seen);
    $display("%0d register writes over directed views and %0d random views",
             writes_done, RANDOM_PHASES);
    if (mismatches == 0 && expected_escapes.size() == 0) begin
      $display("mandelbrot_escape_time_core_tb OK");
    end else begin
      $display("mandelbrot_escape_time_core_tb NOT OK");
    end
    $finish;
  end

endmodule
